// ===== src/lbph_pkg.sv =====
`default_nettype none

package lbph_pkg;

   localparam int LEVEL_W   = 16;
   localparam int IN_W      = 17;
   localparam int COEFF_W   = 16;
   localparam int HOLD_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

   localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd3540;
   localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd640;
   localparam logic [HOLD_W-1:0]  HOLD_RESET    = 8'd120;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD    = 2'd2;

   typedef struct packed {
      logic [COEFF_W-1:0] attack_coeff;
      logic [COEFF_W-1:0] release_coeff;
      logic [HOLD_W-1:0]  hold_frames;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
      logic               holding;
   } result_type;

endpackage

`default_nettype wire

// ===== src/lbph_csr.sv =====
`default_nettype none

module lbph_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [lbph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [lbph_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output lbph_pkg::cfg_type               cfg
);
   import lbph_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ATTACK:  cfg_in.attack_coeff  = csr_wdata;
            CSR_RELEASE: cfg_in.release_coeff = csr_wdata;
            CSR_HOLD:    cfg_in.hold_frames   = csr_wdata[HOLD_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff  <= ATTACK_RESET;
         cfg_ff.release_coeff <= RELEASE_RESET;
         cfg_ff.hold_frames   <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lbph_core.sv =====
`default_nettype none

module lbph_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  wire  [lbph_pkg::LEVEL_W-1:0]  target,
   input  lbph_pkg::cfg_type             cfg,
   output lbph_pkg::result_type          result
);
   import lbph_pkg::*;

   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [LEVEL_W-1:0]       peak_ff, peak_in;
   logic [HOLD_W-1:0]        hold_ff, hold_in;
   logic                     rising;
   logic [LEVEL_W-1:0]       diff;
   logic [COEFF_W-1:0]       coeff;
   logic [LEVEL_W+COEFF_W-1:0] prod;
   logic [LEVEL_W-1:0]       step;
   logic [COEFF_W-3:0]       decay;
   logic [HOLD_W-1:0]        hold_dec;

   always_comb begin
      rising = target > level_ff;
      if (rising) begin
         diff  = target - level_ff;
         coeff = cfg.attack_coeff;
      end else begin
         diff  = level_ff - target;
         coeff = cfg.release_coeff;
      end
      prod = diff * coeff;
      // A fall rounds the step up so the level still floors toward the target.
      if (rising) begin
         step     = prod[LEVEL_W+COEFF_W-1:COEFF_W];
         level_in = level_ff + step;
      end else begin
         step     = prod[LEVEL_W+COEFF_W-1:COEFF_W]
                    + {{(LEVEL_W-1){1'b0}}, |prod[COEFF_W-1:0]};
         level_in = level_ff - step;
      end

      decay    = cfg.release_coeff[COEFF_W-1:2];
      hold_dec = (hold_ff != '0) ? hold_ff - 1'b1 : '0;
      if (level_in >= peak_ff) begin
         peak_in = level_in;
         hold_in = cfg.hold_frames;
      end else begin
         hold_in = hold_dec;
         peak_in = peak_ff;
         if (hold_dec == '0) begin
            peak_in = (peak_ff > {2'b00, decay}) ? peak_ff - {2'b00, decay} : '0;
         end
      end
   end

   assign result.level   = level_in;
   assign result.peak    = peak_in;
   assign result.holding = hold_in != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         peak_ff  <= '0;
         hold_ff  <= '0;
      end else if (advance) begin
         level_ff <= level_in;
         peak_ff  <= peak_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/level_ballistics_peak_hold.sv =====
// Level meter ballistics with peak hold, one request per display frame.
// Request channel (req_): one linear level per frame, 1.0 = 32768; values at
// or above 2.0 are clamped to 65535. Response channel (rsp_): the smoothed
// level, the held peak and a flag that is high while the peak is held.
// Configuration (csr_): index 0 attack coefficient, 1 release coefficient,
// 2 hold frames; other indexes are ignored. Write only while the block is
// idle. csr_ready is always high.
// The request is registered at acceptance, and the core then computes the new
// state and loads the response register. One request per cycle is sustained
// while the response is not stalled; the ballistics and peak update with its
// single multiplier runs combinationally as the state feedback loop.
// When the receiver stalls, the response register holds and one more request
// waits in the input register; req_ready then drops until rsp_ready returns.
// Reset clears the level, peak and hold timer to zero, restores the register
// defaults and empties both stages.
`default_nettype none

module level_ballistics_peak_hold (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [lbph_pkg::IN_W-1:0]       req_level_in,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [lbph_pkg::LEVEL_W-1:0]    rsp_level_out,
   output logic [lbph_pkg::LEVEL_W-1:0]    rsp_peak_out,
   output logic                            rsp_peak_holding,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [lbph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [lbph_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import lbph_pkg::*;

   cfg_type            cfg;
   result_type         result;
   result_type         rsp_ff;
   logic               in_valid_ff, in_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] target_ff;
   logic               out_free;
   logic               advance;
   logic               accept;

   lbph_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbph_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .target  (target_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= req_level_in[IN_W-1] ? LEVEL_MAX : req_level_in[LEVEL_W-1:0];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level_out    = rsp_ff.level;
   assign rsp_peak_out     = rsp_ff.peak;
   assign rsp_peak_holding = rsp_ff.holding;

endmodule

`default_nettype wire
